// ===== src/sap_pkg.sv =====
package sap_pkg;

	// input operation codes
	localparam logic OP_PLACE = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// result kinds
	localparam logic KIND_PLACE = 1'b0;
	localparam logic KIND_PAGE  = 1'b1;

	// configuration register indexes
	localparam int   REG_IDX_BITS        = 1;
	localparam logic REG_PAGE_MAX_WIDTH  = 1'b0;
	localparam logic REG_PAGE_MAX_HEIGHT = 1'b1;

	// page limit after reset, clipped to the coordinate range
	localparam int PAGE_LIMIT_RST = 2048;

endpackage

// ===== src/sap_ifs.sv =====
// rectangle request channel
interface sap_in_if #(
	parameter int COORD_BITS = 13
);
	logic                  valid;
	logic                  ready;
	logic                  op;
	logic [COORD_BITS-1:0] rect_width;
	logic [COORD_BITS-1:0] rect_height;

	modport source (output valid, output op, output rect_width, output rect_height,
		input ready);
	modport sink (input valid, input op, input rect_width, input rect_height,
		output ready);
endinterface

// placement and page result channel
interface sap_out_if #(
	parameter int COORD_BITS = 13,
	parameter int PAGE_BITS  = 8
);
	logic                  valid;
	logic                  ready;
	logic                  kind;
	logic [COORD_BITS-1:0] pos_x;
	logic [COORD_BITS-1:0] pos_y;
	logic [PAGE_BITS-1:0]  page_index;
	logic [COORD_BITS-1:0] page_width;
	logic [COORD_BITS-1:0] page_height;
	logic                  last;

	modport source (output valid, output kind, output pos_x, output pos_y,
		output page_index, output page_width, output page_height, output last,
		input ready);
	modport sink (input valid, input kind, input pos_x, input pos_y,
		input page_index, input page_width, input page_height, input last,
		output ready);
endinterface

// configuration write channel
interface sap_cfg_if #(
	parameter int COORD_BITS = 13
);
	logic                              valid;
	logic                              ready;
	logic [sap_pkg::REG_IDX_BITS-1:0]  index;
	logic [COORD_BITS-1:0]             data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/sap_outbuf.sv =====
module sap_outbuf #(
	parameter int WIDTH = 62
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_en,
	input  logic [1:0]       push_cnt,
	input  logic [WIDTH-1:0] push_data0,
	input  logic [WIDTH-1:0] push_data1,
	output logic             can_push,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic [1:0]       cnt_q;
	logic [WIDTH-1:0] slot0_q;
	logic [WIDTH-1:0] slot1_q;
	logic             pop;

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = slot0_q;
	assign pop       = out_valid && out_ready;

	// a new group may land once the buffer drains to empty this cycle
	assign can_push = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready);

	// beat count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push_en) begin
			cnt_q <= push_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// result slots, head in slot0
	always_ff @(posedge clk) begin
		if (push_en) begin
			slot0_q <= push_data0;
			slot1_q <= push_data1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

// ===== src/shelf_atlas_packer_unit.sv =====
// Shelf packer for atlas pages. Each request beat either places a rectangle
// or flushes the current page. A placement returns one beat, or two when it
// closes the page: the finished page size first, then the placement; the
// last flag marks the final beat of a request. A flush returns the page size
// if the page is not empty and clears all state, page number included.
// Requests enter a one-entry input register, are evaluated combinationally
// against the cursor state, and their beats are registered in the result
// buffer. A new request is taken every cycle while each yields one beat and
// the receiver is ready; a page close stalls the input until the two-entry
// buffer, draining one beat per cycle while the receiver is ready, holds one.
// Limits at indexes 0 (width) and 1 (height) must be written only while no
// request is in flight; the block does not enforce it. Both reset to 2048.
module shelf_atlas_packer_unit #(
	parameter int COORD_BITS = 13,
	parameter int PAGE_BITS  = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	sap_in_if.sink     rect_in,
	sap_out_if.source  res_out,
	sap_cfg_if.sink    cfg
);

	localparam int CW   = COORD_BITS;
	localparam int PW   = PAGE_BITS;
	localparam int CMAX = (1 << CW) - 1;
	localparam int LRST = (sap_pkg::PAGE_LIMIT_RST > CMAX) ? CMAX : sap_pkg::PAGE_LIMIT_RST;
	localparam logic [CW-1:0] LIMIT_RST = CW'(LRST);
	localparam logic [PW-1:0] PAGE_MAX  = '1;

	typedef struct packed {
		logic          kind;
		logic [CW-1:0] pos_x;
		logic [CW-1:0] pos_y;
		logic [PW-1:0] page_index;
		logic [CW-1:0] page_width;
		logic [CW-1:0] page_height;
		logic          last;
	} res_t;

	function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CW] ? {CW{1'b1}} : s[CW-1:0];
	endfunction

	function automatic logic [CW-1:0] max_c(input logic [CW-1:0] a, input logic [CW-1:0] b);
		return (a > b) ? a : b;
	endfunction

	// limits
	logic [CW-1:0] mw_q, mh_q;

	// input register
	logic          v_s1;
	logic          op_s1;
	logic [CW-1:0] w_s1, h_s1;

	// packing state
	logic [CW-1:0] cx_q, cy_q, sh_q, uw_q, uh_q;
	logic [PW-1:0] pn_q;

	// step results
	logic          fire;
	logic          can_push;
	logic          close;
	logic [1:0]    n_res;
	res_t          r0, r1, head;
	logic [CW-1:0] cx_n, cy_n, sh_n, uw_n, uh_n;
	logic [PW-1:0] pn_n;

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mw_q <= LIMIT_RST;
			mh_q <= LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				sap_pkg::REG_PAGE_MAX_WIDTH:  mw_q <= cfg.data;
				sap_pkg::REG_PAGE_MAX_HEIGHT: mh_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// input stage handshake
	assign fire          = v_s1 && can_push;
	assign rect_in.ready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rect_in.valid && rect_in.ready) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rect_in.valid && rect_in.ready) begin
			op_s1 <= rect_in.op;
			w_s1  <= rect_in.rect_width;
			h_s1  <= rect_in.rect_height;
		end
	end

	// one shelf step: new row, page close, placement, extent update
	always_comb begin
		logic [CW:0]   sum_x, sum_y;
		logic          newrow;
		logic [CW-1:0] sh1, cx1, cy1, sh2, cx2, cy2, sh3, cx3, uw2, uh2;
		logic [PW-1:0] pn2;
		sum_x  = {1'b0, cx_q} + {1'b0, w_s1};
		newrow = sum_x >= {1'b0, mw_q};
		sh1    = max_c(sh_q, h_s1);
		cx1    = newrow ? '0 : cx_q;
		cy1    = newrow ? sat_add(cy_q, sh1) : cy_q;
		sh2    = newrow ? h_s1 : sh1;
		sum_y  = {1'b0, cy1} + {1'b0, h_s1};
		close  = (op_s1 == sap_pkg::OP_PLACE) && (sum_y >= {1'b0, mh_q});
		pn2    = (close && (pn_q != PAGE_MAX)) ? pn_q + PW'(1) : pn_q;
		uw2    = close ? '0 : uw_q;
		uh2    = close ? '0 : uh_q;
		cx2    = close ? '0 : cx1;
		cy2    = close ? '0 : cy1;
		sh3    = close ? h_s1 : sh2;
		cx3    = sat_add(cx2, w_s1);

		// finished page beat, reused by flush
		r0.kind        = sap_pkg::KIND_PAGE;
		r0.pos_x       = '0;
		r0.pos_y       = '0;
		r0.page_index  = pn_q;
		r0.page_width  = uw_q;
		r0.page_height = uh_q;
		r0.last        = (op_s1 == sap_pkg::OP_FLUSH);

		// placement beat
		r1.kind        = sap_pkg::KIND_PLACE;
		r1.pos_x       = cx2;
		r1.pos_y       = cy2;
		r1.page_index  = pn2;
		r1.page_width  = '0;
		r1.page_height = '0;
		r1.last        = 1'b1;

		if (op_s1 == sap_pkg::OP_FLUSH) begin
			n_res = ((uw_q != '0) && (uh_q != '0)) ? 2'd1 : 2'd0;
			cx_n  = '0;
			cy_n  = '0;
			sh_n  = '0;
			uw_n  = '0;
			uh_n  = '0;
			pn_n  = '0;
		end else begin
			n_res = close ? 2'd2 : 2'd1;
			if (!close) begin
				r0 = r1;
			end
			cx_n = cx3;
			cy_n = cy2;
			sh_n = sh3;
			uw_n = max_c(uw2, cx3);
			uh_n = max_c(uh2, sat_add(cy2, sh3));
			pn_n = pn2;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			sh_q <= '0;
			uw_q <= '0;
			uh_q <= '0;
			pn_q <= '0;
		end else if (fire) begin
			cx_q <= cx_n;
			cy_q <= cy_n;
			sh_q <= sh_n;
			uw_q <= uw_n;
			uh_q <= uh_n;
			pn_q <= pn_n;
		end
	end

	// result buffer
	sap_outbuf #(
		.WIDTH ($bits(res_t))
	) u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_en    (fire),
		.push_cnt   (n_res),
		.push_data0 (r0),
		.push_data1 (r1),
		.can_push   (can_push),
		.out_valid  (res_out.valid),
		.out_ready  (res_out.ready),
		.out_data   (head)
	);

	assign res_out.kind        = head.kind;
	assign res_out.pos_x       = head.pos_x;
	assign res_out.pos_y       = head.pos_y;
	assign res_out.page_index  = head.page_index;
	assign res_out.page_width  = head.page_width;
	assign res_out.page_height = head.page_height;
	assign res_out.last        = head.last;

	// a page close shows the page beat first, never flagged last
	a_close_first: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && close) |=> (res_out.valid && res_out.kind == sap_pkg::KIND_PAGE
			&& !res_out.last))
		else $error("page close did not lead with the page beat");

	// used width always covers the cursor
	a_extent_cover: assert property (@(posedge clk) disable iff (!arst_n)
		uw_q >= cx_q)
		else $error("used width below cursor");

	// page number only moves forward between flushes
	a_page_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && op_s1 == sap_pkg::OP_PLACE) |=> (pn_q >= $past(pn_q)))
		else $error("page number went backward on a placement");

	// input stalls only behind a held request
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rect_in.ready |-> (v_s1 && !can_push))
		else $error("input stalled without a pending request");

endmodule

// ===== test/tb_shelf_atlas_packer_unit.sv =====
`timescale 1ns / 1ps

module tb_shelf_atlas_packer_unit;

	localparam int CW   = 13;
	localparam int PW   = 8;
	localparam int CMAX = (1 << CW) - 1;

	typedef struct packed {
		logic          kind;
		logic [CW-1:0] pos_x;
		logic [CW-1:0] pos_y;
		logic [PW-1:0] page_index;
		logic [CW-1:0] page_width;
		logic [CW-1:0] page_height;
		logic          last;
	} atlas_beat_t;

	typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic clk;
	logic arst_n;

	sap_in_if  #(.COORD_BITS(CW))                 rect_if ();
	sap_out_if #(.COORD_BITS(CW), .PAGE_BITS(PW)) res_if ();
	sap_cfg_if #(.COORD_BITS(CW))                 cfg_if ();

	shelf_atlas_packer_unit #(
		.COORD_BITS(CW),
		.PAGE_BITS (PW)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rect_in(rect_if),
		.res_out(res_if),
		.cfg    (cfg_if)
	);

	// packer state as the block should hold it
	logic [CW-1:0] lim_width  = CW'(sap_pkg::PAGE_LIMIT_RST);
	logic [CW-1:0] lim_height = CW'(sap_pkg::PAGE_LIMIT_RST);
	logic [CW-1:0] pk_cur_x   = '0;
	logic [CW-1:0] pk_cur_y   = '0;
	logic [CW-1:0] pk_shelf   = '0;
	logic [CW-1:0] pk_used_w  = '0;
	logic [CW-1:0] pk_used_h  = '0;
	logic [PW-1:0] pk_page    = '0;

	atlas_beat_t expected_beats[$];

	int fail_count      = 0;
	int requests_sent   = 0;
	int placements_seen = 0;
	int pages_seen      = 0;
	int limit_sets      = 0;

	// sender and receiver idling controls
	bit       gaps_on       = 1'b1;
	int       burst_left    = 0;
	rx_mode_t rx_mode       = RX_OPEN;
	logic [15:0] stall_pattern = 16'h8001;
	int       hold_request  = 0;
	int       hold_left     = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [CW-1:0] clip_sum(input int a, input int b);
		int s;
		s = a + b;
		clip_sum = (s > CMAX) ? CMAX[CW-1:0] : s[CW-1:0];
	endfunction

	function automatic atlas_beat_t mk_beat(input logic kind, input logic [CW-1:0] px,
		input logic [CW-1:0] py, input logic [PW-1:0] idx, input logic [CW-1:0] pw,
		input logic [CW-1:0] ph, input logic last);
		atlas_beat_t b;
		b.kind        = kind;
		b.pos_x       = px;
		b.pos_y       = py;
		b.page_index  = idx;
		b.page_width  = pw;
		b.page_height = ph;
		b.last        = last;
		mk_beat = b;
	endfunction

	// append one beat to the tail of the expectation queue
	function automatic void queue_beat(input atlas_beat_t b);
		expected_beats.insert(expected_beats.size(), b);
	endfunction

	// shelf placement of one request, queueing the beats it yields
	task automatic pack_predict(input logic op, input logic [CW-1:0] w, input logic [CW-1:0] h);
		int cx;
		int cy;
		int wi;
		int hi;
		wi = w;
		hi = h;
		if (op == sap_pkg::OP_FLUSH) begin
			if (pk_used_w != 0 && pk_used_h != 0)
				queue_beat(mk_beat(sap_pkg::KIND_PAGE, '0, '0, pk_page, pk_used_w,
					pk_used_h, 1'b1));
			pk_cur_x  = '0;
			pk_cur_y  = '0;
			pk_shelf  = '0;
			pk_used_w = '0;
			pk_used_h = '0;
			pk_page   = '0;
		end else begin
			if (h > pk_shelf)
				pk_shelf = h;
			// row full: next shelf below
			cx = pk_cur_x;
			if (cx + wi >= int'(lim_width)) begin
				pk_cur_x = '0;
				pk_cur_y = clip_sum(pk_cur_y, pk_shelf);
				pk_shelf = h;
			end
			// page full: report it and start a fresh one
			cy = pk_cur_y;
			if (cy + hi >= int'(lim_height)) begin
				queue_beat(mk_beat(sap_pkg::KIND_PAGE, '0, '0, pk_page, pk_used_w,
					pk_used_h, 1'b0));
				if (pk_page != '1)
					pk_page = pk_page + 1'b1;
				pk_used_w = '0;
				pk_used_h = '0;
				pk_cur_x  = '0;
				pk_cur_y  = '0;
				pk_shelf  = h;
			end
			queue_beat(mk_beat(sap_pkg::KIND_PLACE, pk_cur_x, pk_cur_y, pk_page, '0, '0,
				1'b1));
			pk_cur_x = clip_sum(pk_cur_x, wi);
			if (pk_cur_x > pk_used_w)
				pk_used_w = pk_cur_x;
			if (clip_sum(pk_cur_y, pk_shelf) > pk_used_h)
				pk_used_h = clip_sum(pk_cur_y, pk_shelf);
		end
	endtask

	// one request beat, with bursty gaps ahead of it
	task automatic send_rect(input logic op, input logic [CW-1:0] w, input logic [CW-1:0] h);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			rect_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		rect_if.valid       <= 1'b1;
		rect_if.op          <= op;
		rect_if.rect_width  <= w;
		rect_if.rect_height <= h;
		@(posedge clk);
		while (!rect_if.ready) @(posedge clk);
		pack_predict(op, w, h);
		requests_sent++;
	endtask

	// stop sending and let every expected beat arrive
	task automatic wait_results_done();
		rect_if.valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		// a flush of an empty page may still be in flight
		repeat (4) @(posedge clk);
	endtask

	// write both page limits back to back; block must be idle
	task automatic set_limits(input logic [CW-1:0] w, input logic [CW-1:0] h);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= sap_pkg::REG_PAGE_MAX_WIDTH;
		cfg_if.data  <= w;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		lim_width = w;
		cfg_if.index <= sap_pkg::REG_PAGE_MAX_HEIGHT;
		cfg_if.data  <= h;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		lim_height = h;
		cfg_if.valid <= 1'b0;
		limit_sets++;
	endtask

	// rectangle side, mostly small against the limit, sometimes at the edges
	function automatic logic [CW-1:0] rand_dim(input logic [CW-1:0] lim);
		int unsigned span;
		int unsigned r;
		span = lim / 6 + 1;
		case ($urandom_range(0, 19))
			0: rand_dim = '0;
			1: rand_dim = '1;
			2: rand_dim = lim;
			3: rand_dim = lim - 1'b1;
			4: begin
				r = $urandom_range(0, CMAX);
				rand_dim = r[CW-1:0];
			end
			default: begin
				r = $urandom_range(0, span);
				rand_dim = r[CW-1:0];
			end
		endcase
	endfunction

	task automatic shuffle_idling();
		gaps_on       = ($urandom_range(0, 3) != 0);
		stall_pattern = 16'($urandom()) | 16'h8001;
		case ($urandom_range(0, 2))
			0: rx_mode = RX_OPEN;
			1: rx_mode = RX_RANDOM;
			default: rx_mode = RX_PATTERN;
		endcase
	endtask

	task automatic send_random(input int n);
		logic op;
		repeat (n) begin
			op = ($urandom_range(0, 39) == 0) ? sap_pkg::OP_FLUSH : sap_pkg::OP_PLACE;
			send_rect(op, rand_dim(lim_width), rand_dim(lim_height));
		end
	endtask

	// receiver: long hold on request, else open, random or patterned stalls
	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN: res_if.ready <= 1'b1;
					RX_RANDOM: res_if.ready <= ($urandom_range(0, 3) != 0);
					default: begin
						res_if.ready <= stall_pattern[0];
						stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
					end
				endcase
			end
		end
	end

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin : check_beats
		atlas_beat_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_beats.size() == 0) begin
				$error("unexpected result beat: kind %0d pos %0d,%0d page %0d",
					res_if.kind, res_if.pos_x, res_if.pos_y, res_if.page_index);
				fail_count++;
			end else begin
				want = expected_beats.pop_front();
				check_field("kind", want.kind, res_if.kind);
				check_field("pos_x", want.pos_x, res_if.pos_x);
				check_field("pos_y", want.pos_y, res_if.pos_y);
				check_field("page_index", want.page_index, res_if.page_index);
				check_field("page_width", want.page_width, res_if.page_width);
				check_field("page_height", want.page_height, res_if.page_height);
				check_field("last", want.last, res_if.last);
				if (want.kind == sap_pkg::KIND_PAGE)
					pages_seen++;
				else
					placements_seen++;
			end
		end
	end

	// reset limits: zero rect, empty flush, oversized, exact width fit, saturation
	task automatic test_reset_limits();
		send_rect(sap_pkg::OP_PLACE, 13'd0, 13'd0);
		send_rect(sap_pkg::OP_FLUSH, 13'd0, 13'd0);
		send_rect(sap_pkg::OP_PLACE, 13'd4096, 13'd4096);
		send_rect(sap_pkg::OP_PLACE, 13'd2047, 13'd1);
		send_rect(sap_pkg::OP_PLACE, 13'd1, 13'd1);
		send_rect(sap_pkg::OP_PLACE, 13'd8191, 13'd8191);
		send_rect(sap_pkg::OP_PLACE, 13'd0, 13'd2048);
		send_rect(sap_pkg::OP_PLACE, 13'd2047, 13'd2047);
		send_rect(sap_pkg::OP_FLUSH, 13'd8191, 13'd8191);
		send_rect(sap_pkg::OP_FLUSH, 13'd0, 13'd0);
		send_rect(sap_pkg::OP_PLACE, 13'd100, 13'd100);
		wait_results_done();
	endtask

	// zero limits, one-pixel limits, full-range limits with coordinate clipping
	task automatic test_limit_extremes();
		set_limits(13'd0, 13'd0);
		send_rect(sap_pkg::OP_PLACE, 13'd5, 13'd5);
		send_rect(sap_pkg::OP_PLACE, 13'd0, 13'd0);
		send_rect(sap_pkg::OP_PLACE, 13'd4096, 13'd1);
		send_rect(sap_pkg::OP_FLUSH, 13'd0, 13'd0);
		wait_results_done();
		set_limits(13'd1, 13'd1);
		send_rect(sap_pkg::OP_PLACE, 13'd0, 13'd0);
		send_rect(sap_pkg::OP_PLACE, 13'd1, 13'd0);
		send_rect(sap_pkg::OP_PLACE, 13'd0, 13'd1);
		send_rect(sap_pkg::OP_FLUSH, 13'd0, 13'd0);
		wait_results_done();
		set_limits(13'd8191, 13'd8191);
		send_rect(sap_pkg::OP_PLACE, 13'd10, 13'd8000);
		send_rect(sap_pkg::OP_PLACE, 13'd8191, 13'd100);
		send_rect(sap_pkg::OP_PLACE, 13'd8191, 13'd90);
		send_rect(sap_pkg::OP_PLACE, 13'd1, 13'd8190);
		send_rect(sap_pkg::OP_PLACE, 13'd8191, 13'd8191);
		send_rect(sap_pkg::OP_FLUSH, 13'd0, 13'd0);
		wait_results_done();
	endtask

	// every rect opens a new page until the page number sticks at its top
	task automatic test_page_saturation();
		shuffle_idling();
		set_limits(13'd0, 13'd0);
		repeat (270)
			send_rect(sap_pkg::OP_PLACE, rand_dim(13'd64), rand_dim(13'd64));
		send_rect(sap_pkg::OP_FLUSH, 13'd0, 13'd0);
		wait_results_done();
	endtask

	// random packing over a spread of limit settings
	task automatic test_random_sweep();
		logic [CW-1:0] sweep_w[8];
		logic [CW-1:0] sweep_h[8];
		sweep_w = '{13'd2048, 13'd4096, 13'd100, 13'd37, 13'd4096, 13'd8191, 13'd0, 13'd0};
		sweep_h = '{13'd2048, 13'd4096, 13'd60, 13'd4096, 13'd16, 13'd8191, 13'd0, 13'd0};
		sweep_w[6] = 13'($urandom_range(1, 4096));
		sweep_h[6] = 13'($urandom_range(1, 4096));
		sweep_w[7] = 13'($urandom_range(1, 300));
		sweep_h[7] = 13'($urandom_range(1, 300));
		for (int i = 0; i < 8; i++) begin
			shuffle_idling();
			set_limits(sweep_w[i], sweep_h[i]);
			send_random(80);
			wait_results_done();
		end
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		set_limits(13'd300, 13'd300);
		gaps_on      = 1'b0;
		rx_mode      = RX_OPEN;
		hold_request = 200;
		send_random(60);
		wait_results_done();
	endtask

	// sender pauses mid-stream until every result is back
	task automatic test_sender_pause();
		shuffle_idling();
		set_limits(13'd512, 13'd256);
		send_random(40);
		wait_results_done();
		send_random(40);
		wait_results_done();
	endtask

	initial begin
		arst_n              <= 1'b0;
		rect_if.valid       <= 1'b0;
		rect_if.op          <= sap_pkg::OP_PLACE;
		rect_if.rect_width  <= '0;
		rect_if.rect_height <= '0;
		cfg_if.valid        <= 1'b0;
		cfg_if.index        <= sap_pkg::REG_PAGE_MAX_WIDTH;
		cfg_if.data         <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_limits();
		test_limit_extremes();
		test_page_saturation();
		test_random_sweep();
		test_backpressure();
		test_sender_pause();

		wait_results_done();
		repeat (20) @(posedge clk);
		$display("packed %0d requests across %0d limit settings", requests_sent, limit_sets);
		$display("checked %0d placements and %0d finished pages", placements_seen, pages_seen);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
